// ----- rtl/gtpms_pkg.sv -----
// shared types and constants of the grid two-path max-sum unit
`default_nettype none

package gtpms_pkg;

  // field widths of the item and result channels
  localparam int FUNC_W  = 1;
  localparam int ROW_W   = 5;
  localparam int COL_W   = 5;
  localparam int CVAL_W  = 16;
  localparam int TOTAL_W = 22;
  localparam int GSIZE_W = 5;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // item function codes
  localparam logic [FUNC_W-1:0] FUNC_WRITE   = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 1'b1;

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_GRID_SIZE = 1'b0;  // register index bit paddr[2]

  // steps of one dp entry
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_CLEAR_ACC = 3'd0;
  localparam logic [STEP_W-1:0] STEP_MAX_LAST  = 3'd4;
  localparam logic [STEP_W-1:0] STEP_CAPTURE_A = 3'd1;
  localparam logic [STEP_W-1:0] STEP_ADD_A     = 3'd5;
  localparam logic [STEP_W-1:0] STEP_WRITE     = 3'd6;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_INIT_RD,
    S_INIT_WR,
    S_ENTRY,
    S_DONE
  } gtpms_state_t;

endpackage

`default_nettype wire

// ----- rtl/gtpms_ram.sv -----
// generic single-write, single-read ram with registered read data
`default_nettype none

module gtpms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/grid_two_path_max_sum_unit.sv -----
// grid two-path max-sum unit: cell store, dp sequencer and configuration port
//
// usage:
//   items enter on in_valid/in_ready with fields func, row, col, cell_value.
//   a write item (func = 0) stores one cell at 1-based row/col and gives no
//   result. a compute item (func = 1) runs the dp for the n-by-n grid
//   (n = grid_size, clamped to 1..MAX_SIDE) and gives one result item,
//   best_total, on out_valid/out_ready.
//   a compute item works through the dp entries one at a time, where the
//   entry count is the sum over diagonals 1..2n-2 of the squared
//   diagonal length (2735 entries for n = 16). each entry takes seven steps,
//   due to the single read port of the diagonal table (four
//   predecessor reads) and the one shared add/max unit. in_ready is low while
//   a compute item is at work. write items sustain one per cycle while idle.
//   reset: all MAX_SIDE*MAX_SIDE cells of the cell store are swept to zero,
//   one cell per cycle, with in_ready low; grid_size returns to 1 and
//   the apb port works throughout.
//   a result waits in the output register while the receiver stalls; write
//   items are still taken meanwhile, and a following compute item holds its
//   total until the output register frees up.
`default_nettype none

module grid_two_path_max_sum_unit
  import gtpms_pkg::*;
#(
  parameter int MAX_SIDE   = 16,
  parameter int VALUE_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // item channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [FUNC_W-1:0]  func,
  input  wire logic [ROW_W-1:0]   row,
  input  wire logic [COL_W-1:0]   col,
  input  wire logic [CVAL_W-1:0]  cell_value,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [TOTAL_W-1:0]      best_total,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0]      prdata,
  output logic                    pready
);

  localparam int BANK_SIZE = MAX_SIDE * MAX_SIDE;
  localparam int CA_W      = $clog2(BANK_SIZE);
  localparam int DA_W      = $clog2(2 * BANK_SIZE);
  localparam int IDX_W     = $clog2(MAX_SIDE);
  localparam int N_W       = $clog2(MAX_SIDE + 1);
  localparam int D_W       = $clog2(2 * MAX_SIDE);
  localparam int OP_W      = (VALUE_BITS > TOTAL_W) ? VALUE_BITS : TOTAL_W;
  localparam int SUM_W     = OP_W + 1;

  // control registers
  gtpms_state_t        state, state_next;
  logic [GSIZE_W-1:0]  grid_size;
  logic [CA_W-1:0]     clr_addr;

  // sequencer registers
  logic [N_W-1:0]      n_side, n_side_next;
  logic [D_W-1:0]      diag, diag_next;
  logic [IDX_W-1:0]    pos_a, pos_a_next;
  logic [IDX_W-1:0]    pos_b, pos_b_next;
  logic [STEP_W-1:0]   step, step_next;
  logic                cand_ok_q;

  // datapath registers
  logic [TOTAL_W-1:0]    acc, acc_next;
  logic [VALUE_BITS-1:0] cell_a;

  // ram ports
  logic                  cs_we;
  logic [CA_W-1:0]       cs_waddr, cs_raddr;
  logic [VALUE_BITS-1:0] cs_wdata, cs_rdata;
  logic                  dt_we;
  logic [DA_W-1:0]       dt_waddr, dt_raddr;
  logic [TOTAL_W-1:0]    dt_rdata;

  logic in_fire, cfg_write;
  logic wr_in_range;
  logic [31:0] cval_ext;

  // diagonal bounds
  logic [D_W-1:0] n_ext, nm1, lo, hi, plo, phi, lo_after, d_last;
  logic [D_W-1:0] a_ext, b_ext, pa, pb, row_sel;
  logic           cand_ok, last_entry;

  // shared add/max unit
  logic               unit_max;
  logic [TOTAL_W-1:0] unit_x;
  logic [OP_W-1:0]    unit_y;
  logic [SUM_W-1:0]   unit_sum;
  logic [TOTAL_W-1:0] unit_out;

  gtpms_ram #(.WIDTH(VALUE_BITS), .DEPTH(BANK_SIZE)) u_cell_store (
    .clk   (clk),
    .we    (cs_we),
    .waddr (cs_waddr),
    .wdata (cs_wdata),
    .raddr (cs_raddr),
    .rdata (cs_rdata)
  );

  gtpms_ram #(.WIDTH(TOTAL_W), .DEPTH(2 * BANK_SIZE)) u_diag_table (
    .clk   (clk),
    .we    (dt_we),
    .waddr (dt_waddr),
    .wdata (unit_out),
    .raddr (dt_raddr),
    .rdata (dt_rdata)
  );

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_GRID_SIZE) ? PDATA_W'(grid_size) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size <= GSIZE_W'(1);
    end else if (cfg_write && paddr[2] == REG_GRID_SIZE) begin
      grid_size <= pwdata[GSIZE_W-1:0];
    end
  end

  assign in_fire     = in_valid && in_ready;
  assign wr_in_range = (row != '0) && (32'(row) <= MAX_SIDE) &&
                       (col != '0) && (32'(col) <= MAX_SIDE);
  assign cval_ext    = 32'(cell_value);

  // diagonal bounds of the current and previous diagonal
  always_comb begin
    n_ext    = D_W'(n_side);
    nm1      = n_ext - D_W'(1);
    lo       = (diag > nm1) ? diag - nm1 : '0;
    hi       = (diag < nm1) ? diag : nm1;
    plo      = (diag > n_ext) ? diag - n_ext : '0;
    phi      = (diag < n_ext) ? diag - D_W'(1) : nm1;
    lo_after = (diag >= nm1) ? diag - nm1 + D_W'(1) : '0;
    d_last   = (n_ext << 1) - D_W'(2);
    a_ext    = D_W'(pos_a);
    b_ext    = D_W'(pos_b);
    // predecessor candidate picked by the low two step bits
    pa       = a_ext - D_W'(step[1]);
    pb       = b_ext - D_W'(step[0]);
    cand_ok  = !(pos_a == '0 && step[1]) && !(pos_b == '0 && step[0]) &&
               (pa >= plo) && (pa <= phi) && (pb >= plo) && (pb <= phi);
    last_entry = (b_ext == hi) && (a_ext == hi) && (diag == d_last);
    row_sel  = (step == STEP_CLEAR_ACC) ? a_ext : b_ext;
  end

  // shared unit: max of accumulator and a predecessor, or saturating add
  always_comb begin
    unit_max = (state == S_ENTRY) && (step >= STEP_CAPTURE_A) &&
               (step <= STEP_MAX_LAST);
    unit_x   = (state == S_INIT_WR) ? '0 : acc;
    if (unit_max) begin
      unit_y = OP_W'(dt_rdata);
    end else if (state == S_ENTRY && step == STEP_ADD_A) begin
      unit_y = OP_W'(cell_a);
    end else if (state == S_ENTRY && pos_a == pos_b) begin
      unit_y = '0;  // shared cell counted once
    end else begin
      unit_y = OP_W'(cs_rdata);
    end
    unit_sum = SUM_W'(unit_x) + SUM_W'(unit_y);
    if (unit_max) begin
      unit_out = (OP_W'(unit_x) > unit_y) ? unit_x : unit_y[TOTAL_W-1:0];
    end else if (unit_sum > SUM_W'(TOTAL_MAX)) begin
      unit_out = TOTAL_MAX;
    end else begin
      unit_out = unit_sum[TOTAL_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (32'(clr_addr) == BANK_SIZE - 1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire && func == FUNC_COMPUTE) begin
          state_next = S_INIT_RD;
        end
      end
      S_INIT_RD: state_next = S_INIT_WR;
      S_INIT_WR: state_next = (n_side == N_W'(1)) ? S_DONE : S_ENTRY;
      S_ENTRY: begin
        if (step == STEP_WRITE && last_entry) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    in_ready = (state == S_IDLE);
    cs_we    = 1'b0;
    cs_waddr = clr_addr;
    cs_wdata = '0;
    case (state)
      S_CLEAR: begin
        cs_we = 1'b1;
      end
      S_IDLE: begin
        cs_we    = in_fire && (func == FUNC_WRITE) && wr_in_range;
        cs_waddr = CA_W'(row - ROW_W'(1)) * CA_W'(MAX_SIDE) + CA_W'(col - COL_W'(1));
        cs_wdata = cval_ext[VALUE_BITS-1:0];
      end
      default: begin
        cs_we = 1'b0;
      end
    endcase
    cs_raddr = CA_W'(row_sel) * CA_W'(MAX_SIDE) + CA_W'(diag - row_sel);
    dt_raddr = DA_W'(~diag[0]) * DA_W'(BANK_SIZE) + DA_W'(pa) * DA_W'(MAX_SIDE) +
               DA_W'(pb);
    dt_waddr = DA_W'(diag[0]) * DA_W'(BANK_SIZE) + DA_W'(pos_a) * DA_W'(MAX_SIDE) +
               DA_W'(pos_b);
    dt_we    = (state == S_INIT_WR) || (state == S_ENTRY && step == STEP_WRITE);
  end

  // sequencer and accumulator next values
  always_comb begin
    n_side_next = n_side;
    diag_next   = diag;
    pos_a_next  = pos_a;
    pos_b_next  = pos_b;
    step_next   = step;
    acc_next    = acc;
    case (state)
      S_IDLE: begin
        // clamp grid size to 1..MAX_SIDE
        if (grid_size == '0) begin
          n_side_next = N_W'(1);
        end else if (32'(grid_size) > MAX_SIDE) begin
          n_side_next = N_W'(MAX_SIDE);
        end else begin
          n_side_next = N_W'(grid_size);
        end
        diag_next  = '0;
        pos_a_next = '0;
        pos_b_next = '0;
        step_next  = STEP_CLEAR_ACC;
      end
      S_INIT_WR: begin
        acc_next  = unit_out;
        diag_next = D_W'(1);
      end
      S_ENTRY: begin
        step_next = step + STEP_W'(1);
        if (step == STEP_CLEAR_ACC) begin
          acc_next = '0;
        end else if (unit_max) begin
          if (cand_ok_q) begin
            acc_next = unit_out;
          end
        end else begin
          acc_next = unit_out;
        end
        if (step == STEP_WRITE) begin
          step_next = STEP_CLEAR_ACC;
          if (b_ext != hi) begin
            pos_b_next = pos_b + IDX_W'(1);
          end else if (a_ext != hi) begin
            pos_a_next = pos_a + IDX_W'(1);
            pos_b_next = IDX_W'(lo);
          end else if (!last_entry) begin
            diag_next  = diag + D_W'(1);
            pos_a_next = IDX_W'(lo_after);
            pos_b_next = IDX_W'(lo_after);
          end
        end
      end
      default: begin
        acc_next = acc;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + CA_W'(1);
      end
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload and sequencer registers
  always_ff @(posedge clk) begin
    n_side    <= n_side_next;
    diag      <= diag_next;
    pos_a     <= pos_a_next;
    pos_b     <= pos_b_next;
    step      <= step_next;
    acc       <= acc_next;
    cand_ok_q <= cand_ok;
    if (state == S_ENTRY && step == STEP_CAPTURE_A) begin
      cell_a <= cs_rdata;
    end
    if (state == S_DONE && (!out_valid || out_ready)) begin
      best_total <= acc;
    end
  end

endmodule

`default_nettype wire
